### hdl/srcl_pkg.sv
// Shared types and constants for the steering rate estimator.
// No dependencies; every other file but srcl_if.sv imports this package.
`default_nettype none

package srcl_pkg;

  localparam int MAX_ORDER = 4;
  localparam int STAGE_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W     = $clog2(MAX_ORDER + 1);

  localparam int DIVIDEND_W = 40;
  localparam int DIVISOR_W  = 31;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Q2.13 angle steps per microsecond to Q15.16 rad/s: 2^16 * 1e6 / 2^13.
  localparam logic [22:0] RATE_SCALE = 23'd8000000;
  // round(2*pi*2^46/16e6) for the exponent of the filter coefficient.
  localparam logic [24:0] EXP_K      = 25'd27633741;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [45:0] X_LIMIT    = 46'd12 << 30;
  // ceil(2^32/3) and ceil(2^32/5); exact floor quotients for operands below 2^30.
  localparam logic [31:0] RECIP3     = 32'd1431655766;
  localparam logic [31:0] RECIP5     = 32'd858993460;

  localparam logic REG_CUTOFF = 1'b0;
  localparam logic REG_ORDER  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_RAWMUL, S_DIV, S_TDIV, S_FCHK, S_PMUL, S_XHI, S_XLO,
    S_XCHK, S_TMUL, S_SQ, S_ALPHA, S_BLA, S_BLB, S_BLW, S_OUT
  } srcl_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } srcl_div_req_t;

endpackage

`default_nettype wire

### hdl/srcl_if.sv
// Channel interfaces for samples in and rates out.
// Depends on nothing; used by the top level.
`default_nettype none

interface srcl_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steer_angle;
  logic        [31:0] time_stamp;
  modport source (output valid, steer_angle, time_stamp, input ready);
  modport sink   (input valid, steer_angle, time_stamp, output ready);
endinterface

interface srcl_rate_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] steer_rate;
  logic               first_sample;
  modport source (output valid, steer_rate, first_sample, input ready);
  modport sink   (input valid, steer_rate, first_sample, output ready);
endinterface

`default_nettype wire

### hdl/srcl_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on srcl_pkg for widths and the request struct.
`default_nettype none

module srcl_divider
  import srcl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire srcl_div_req_t         req,
  output logic                       busy,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVISOR_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
      end
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### hdl/steer_rate_cascade_lowpass.sv
// Steering rate estimator on one shared 33x33 multiplier and a bit-serial 40-bit divider.
// A sample runs through the raw rate divide, the filter coefficient and then each stage;
// a bypassed filter skips coefficient and stages, and a first sample is output directly.
// A new sample is taken only once the last rate is on the output; a stalled rate delays it.
// Reset (synchronous, active high) clears the filter stages, forgets the previous
// sample and sets cutoff to 10 Hz and filter order to one.
`default_nettype none

module steer_rate_cascade_lowpass
  import srcl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  srcl_sample_if.sink      samples,
  srcl_rate_if.source      rates,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // Configuration registers, to be written only while idle; the block does not enforce this.
  logic [15:0] cutoff_freq;
  logic [2:0]  filter_order;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_freq  <= 16'd160;
      filter_order <= 3'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_CUTOFF: cutoff_freq  <= pwdata[15:0];
        REG_ORDER:  filter_order <= pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CUTOFF: prdata = {16'd0, cutoff_freq};
      REG_ORDER:  prdata = {29'd0, filter_order};
    endcase
  end

  // Sequencer state and the working registers of the datapath.
  srcl_state_t state, state_next;

  logic                     have_previous;
  logic signed [15:0]       previous_angle;
  logic        [31:0]       previous_stamp;
  logic signed [31:0]       stage_values [MAX_ORDER];

  logic        [31:0]       dt;
  logic        [15:0]       mag;
  logic                     neg;
  logic                     first_flag;
  logic signed [31:0]       val;
  logic        [46:0]       pval;
  logic        [44:0]       xhi;
  logic        [45:0]       xval;
  logic        [25:0]       yval;
  logic        [30:0]       term;
  logic        [25:0]       tnum;
  logic signed [32:0]       sum;
  logic        [30:0]       vsq;
  logic        [15:0]       alpha;
  logic        [2:0]        cnt;
  logic        [CNT_W-1:0]  stage;
  logic signed [48:0]       acc;

  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       prod;

  srcl_div_req_t            div_req;
  logic                     div_busy, div_done;
  logic [DIVIDEND_W-1:0]    div_quo;

  // Combinational helpers.
  logic        [31:0]       diff;
  logic signed [16:0]       delta;
  logic                     dt_pos, filt_on;
  logic        [CNT_W-1:0]  n_use;
  logic        [25:0]       tquo;
  logic signed [32:0]       sum_new;
  logic        [17:0]       alpha_wide;
  logic signed [48:0]       acc_rnd;
  logic                     out_free;

  assign diff    = samples.time_stamp - previous_stamp;
  assign delta   = 17'(samples.steer_angle) - 17'(previous_angle);
  assign dt_pos  = !dt[31] && (dt != 32'd0);
  assign filt_on = dt_pos && (filter_order != 3'd0) && (cutoff_freq != 16'd0);
  assign out_free = !rates.valid || rates.ready;

  always_comb begin
    if (32'(filter_order) > 32'(MAX_ORDER)) begin
      n_use = CNT_W'(MAX_ORDER);
    end else begin
      n_use = CNT_W'(filter_order);
    end
  end

  // Series term divided by k: shifts for 1, 2 and 4, a reciprocal product for 3 and 5.
  always_comb begin
    unique case (cnt)
      3'd1:    tquo = tnum;
      3'd2:    tquo = tnum >> 1;
      3'd4:    tquo = tnum >> 2;
      default: tquo = prod[57:32];
    endcase
  end

  // Odd series terms subtract, even ones add.
  always_comb begin
    if (cnt[0]) begin
      sum_new = sum - $signed(33'(tquo));
    end else begin
      sum_new = sum + $signed(33'(tquo));
    end
  end

  assign alpha_wide = 18'((32'(vsq) + 32'd8192) >> 14);
  assign acc_rnd    = acc + 49'sd32768;

  // Shared multiplier: the state picks its operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_RAWMUL: begin
        mul_a = $signed(33'(mag));
        mul_b = $signed(33'(RATE_SCALE));
      end
      S_PMUL: begin
        mul_a = $signed(33'(cutoff_freq));
        mul_b = $signed(33'(dt[30:0]));
      end
      S_XHI: begin
        mul_a = $signed(33'(pval[35:16]));
        mul_b = $signed(33'(EXP_K));
      end
      S_XLO: begin
        mul_a = $signed(33'(pval[15:0]));
        mul_b = $signed(33'(EXP_K));
      end
      S_TMUL: begin
        mul_a = $signed(33'(term));
        mul_b = $signed(33'(yval));
      end
      S_TDIV: begin
        mul_a = $signed(33'(tnum));
        mul_b = (cnt == 3'd3) ? $signed(33'(RECIP3)) : $signed(33'(RECIP5));
      end
      S_SQ: begin
        mul_a = $signed(33'(vsq));
        mul_b = $signed(33'(vsq));
      end
      S_BLA: begin
        mul_a = $signed(33'(alpha));
        mul_b = 33'(stage_values[stage[STAGE_W-1:0]]);
      end
      S_BLB: begin
        mul_a = $signed(33'(17'h10000 - 17'(alpha)));
        mul_b = 33'(val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // The divider only serves the raw rate, which divides by dt.
  always_comb begin
    div_req = '0;
    if (state == S_RAWMUL) begin
      div_req.start    = 1'b1;
      div_req.dividend = prod[39:0] + 40'(dt[31:1]);
      div_req.divisor  = dt[30:0];
    end
  end

  srcl_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          if (!have_previous) begin
            state_next = S_OUT;
          end else if (!diff[31] && (diff[30:1] != 30'd0)) begin
            state_next = S_RAWMUL;
          end else begin
            state_next = S_FCHK;
          end
        end
      end
      S_RAWMUL: state_next = S_DIV;
      S_DIV:    if (div_done) state_next = S_FCHK;
      S_TDIV:   state_next = (cnt == 3'd5) ? S_SQ : S_TMUL;
      S_FCHK:   state_next = filt_on ? S_PMUL : S_OUT;
      S_PMUL:   state_next = S_XHI;
      S_XHI:    state_next = (pval[46:36] != 11'd0) ? S_BLA : S_XLO;
      S_XLO:    state_next = S_XCHK;
      S_XCHK:   state_next = (xval >= X_LIMIT) ? S_BLA : S_TMUL;
      S_TMUL:   state_next = S_TDIV;
      S_SQ:     if (cnt == 3'd7) state_next = S_ALPHA;
      S_ALPHA:  state_next = S_BLA;
      S_BLA:    state_next = S_BLB;
      S_BLB:    state_next = S_BLW;
      S_BLW:    state_next = (stage + 1'b1 == n_use) ? S_OUT : S_BLA;
      S_OUT:    if (out_free) state_next = S_IDLE;
    endcase
  end

  // Control state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      previous_angle <= '0;
      previous_stamp <= '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        stage_values[i] <= '0;
      end
      rates.valid <= 1'b0;
    end else begin
      if (state == S_IDLE && samples.valid) begin
        have_previous  <= 1'b1;
        previous_angle <= samples.steer_angle;
        previous_stamp <= samples.time_stamp;
      end
      if (state == S_BLW) begin
        stage_values[stage[STAGE_W-1:0]] <= acc_rnd[47:16];
      end
      if (state == S_OUT && out_free) begin
        rates.valid <= 1'b1;
      end else if (rates.ready) begin
        rates.valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        dt         <= diff;
        neg        <= delta[16];
        mag        <= delta[16] ? 16'(-delta) : delta[15:0];
        first_flag <= !have_previous;
        val        <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          if (neg) begin
            val <= (div_quo > 40'h80000000) ? 32'sh80000000 : -$signed(div_quo[31:0]);
          end else begin
            val <= (div_quo > 40'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(div_quo[31:0]);
          end
        end
      end
      S_TDIV: begin
        term <= 31'(tquo);
        sum  <= sum_new;
        cnt  <= cnt + 1'b1;
        if (cnt == 3'd5) begin
          vsq <= sum_new[32] ? 31'd0 : sum_new[30:0];
          cnt <= '0;
        end
      end
      S_FCHK:  stage <= '0;
      S_PMUL:  pval  <= prod[46:0];
      S_XHI: begin
        xhi   <= prod[44:0];
        alpha <= '0;
      end
      S_XLO:   xval <= 46'(xhi) + 46'(prod[40:16]);
      S_XCHK: begin
        yval <= xval[33:8];
        term <= Q30_ONE;
        sum  <= $signed(33'(Q30_ONE));
        cnt  <= 3'd1;
      end
      S_TMUL:  tnum <= prod[55:30];
      S_SQ: begin
        vsq <= prod[60:30];
        cnt <= cnt + 1'b1;
      end
      S_ALPHA: alpha <= (alpha_wide > 18'd65535) ? 16'hFFFF : alpha_wide[15:0];
      S_BLA:   acc <= prod[48:0];
      S_BLB:   acc <= acc + prod[48:0];
      S_BLW: begin
        val   <= acc_rnd[47:16];
        stage <= stage + 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          rates.steer_rate   <= val;
          rates.first_sample <= first_flag;
        end
      end
      default: begin
      end
    endcase
  end

  // A first sample always answers with a zero rate.
  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    rates.valid && rates.first_sample |-> rates.steer_rate == 32'sd0)
    else $error("first sample with nonzero rate");

  // After a transfer in, no new sample is taken until the result is built.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("sample taken while busy");

  // The divider is only started while it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

### verif/srcl_rate_checker.sv
// Watches the sample, rate and register ports of the steering rate estimator,
// predicts every rate and compares it. Depends on srcl_pkg and srcl_if.sv.
`default_nettype none

module srcl_rate_checker
  import srcl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  srcl_sample_if           samples,
  srcl_rate_if             rates,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] rate;
    logic               first;
  } rate_t;

  rate_t              rate_q[$];
  logic        [15:0] cutoff;
  logic        [2:0]  order;
  logic               seen_first;
  logic signed [15:0] last_angle;
  logic        [31:0] last_stamp;
  logic signed [31:0] stage [MAX_ORDER];

  assign pending = rate_q.size();

  // Filter coefficient in Q0.16 from P = cutoff * dt.
  function automatic logic [15:0] coef_of(input longint unsigned p);
    longint unsigned x, y, term, v;
    longint          sum;
    if (p >= (64'd1 << 36)) return 16'd0;
    x = (p * longint'(EXP_K)) >> 16;
    if (x >= (64'd12 << 30)) return 16'd0;
    y    = x >> 8;
    term = 64'd1 << 30;
    sum  = longint'(64'd1 << 30);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * y) >> 30) / k;
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    v = (sum < 0) ? 64'd0 : longint'(sum);
    for (int k = 0; k < 8; k++) v = (v * v) >> 30;
    v = (v + 64'd8192) >> 14;
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic signed [31:0] smooth(input logic [15:0] a,
                                                input logic signed [31:0] s,
                                                input logic signed [31:0] x);
    longint t;
    t = longint'(a) * longint'(s) + (longint'(65536) - longint'(a)) * longint'(x);
    t = (t + 32768) >>> 16;
    return t[31:0];
  endfunction

  function automatic rate_t predict_rate(input logic signed [15:0] ang,
                                         input logic [31:0] ts);
    rate_t           r;
    logic [31:0]     diff;
    longint          dt, delta, raw, q;
    longint unsigned mag;
    logic [15:0]     a;
    int              n;
    logic signed [31:0] x;
    if (!seen_first) begin
      seen_first = 1'b1;
      last_angle = ang;
      last_stamp = ts;
      r.rate = '0;
      r.first = 1'b1;
      return r;
    end
    diff  = ts - last_stamp;
    dt    = longint'(signed'(diff));
    delta = longint'(ang) - longint'(last_angle);
    last_angle = ang;
    last_stamp = ts;
    raw = 0;
    if (dt > 1) begin
      mag = (delta < 0) ? -delta : delta;
      q = longint'((mag * 64'd8000000 + dt / 2) / dt);
      if (delta < 0) raw = (q > 64'h8000_0000) ? -64'sh8000_0000 : -q;
      else raw = (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : q;
    end
    x = raw[31:0];
    if (dt > 0 && order != 0 && cutoff != 0) begin
      n = (order > MAX_ORDER) ? MAX_ORDER : order;
      a = coef_of(longint'(cutoff) * dt);
      for (int i = 0; i < n; i++) begin
        stage[i] = smooth(a, stage[i], x);
        x = stage[i];
      end
    end
    r.rate = x;
    r.first = 1'b0;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    rate_t want;
    if (rst) begin
      cutoff     = 16'd160;
      order      = 3'd1;
      seen_first = 1'b0;
      last_angle = '0;
      last_stamp = '0;
      for (int i = 0; i < MAX_ORDER; i++) stage[i] = '0;
      rate_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr >> 2 == 3'(REG_CUTOFF)) cutoff = pwdata[15:0];
        else if (paddr >> 2 == 3'(REG_ORDER)) order = pwdata[2:0];
      end
      if (samples.valid && samples.ready)
        rate_q.push_back(predict_rate(samples.steer_angle, samples.time_stamp));
      if (rates.valid && rates.ready) begin
        if (rate_q.size() == 0) begin
          report("unexpected rate", rates.steer_rate, 0);
        end else begin
          want = rate_q.pop_front();
          if (rates.steer_rate !== want.rate)
            report("steer_rate", rates.steer_rate, want.rate);
          if (rates.first_sample !== want.first)
            report("first_sample", rates.first_sample, want.first);
        end
      end
    end
  end

  initial errors = 0;

endmodule

`default_nettype wire

### verif/tb_steer_rate_cascade_lowpass.sv
// Top of the steering rate estimator testbench: clock, reset, stimulus and verdict.
// Depends on srcl_pkg, srcl_if.sv, the block and srcl_rate_checker.
`default_nettype none

module tb_steer_rate_cascade_lowpass;
  import srcl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;  // cycles without any transfer
  localparam int DRAIN_WAIT = 400;   // above the slowest item of the block

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          sent = 0, phases = 0;
  int          cycle_no = 0;
  logic signed [15:0] cur_angle = '0;
  logic        [31:0] cur_stamp = '0;

  srcl_sample_if samples();
  srcl_rate_if   rates();

  initial begin
    samples.valid       = 1'b0;
    samples.steer_angle = '0;
    samples.time_stamp  = '0;
    rates.ready         = 1'b0;
  end

  steer_rate_cascade_lowpass i_dut (
    .clk, .rst, .samples(samples.sink), .rates(rates.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  srcl_rate_checker i_chk (
    .clk, .rst, .samples, .rates, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .errors, .pending
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver changes its stall pattern over the run: always ready, coin flips,
  // and a fixed repeating on-off pattern.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst) begin
      rates.ready <= 1'b0;
    end else begin
      case ((cycle_no / 300) % 3)
        0: rates.ready <= 1'b1;
        1: rates.ready <= $urandom_range(0, 1);
        default: rates.ready <= (cycle_no % 8) < 3;
      endcase
    end
  end

  // The watchdog ends a run in which no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (rates.valid && rates.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // One sample transfer. Bursts of random length are separated by gaps, so valid
  // is never lowered and raised in one step. Ready is looked at on the falling edge,
  // where it is stable up to the next rising edge.
  task automatic send_sample(input logic signed [15:0] ang, input logic [31:0] ts);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    samples.valid       <= 1'b1;
    samples.steer_angle <= ang;
    samples.time_stamp  <= ts;
    forever begin
      @(negedge clk);
      if (samples.ready) break;
    end
    @(posedge clk);
    burst_left--;
    sent++;
    if (burst_left == 0) samples.valid <= 1'b0;
    cur_angle = ang;
    cur_stamp = ts;
  endtask

  // Step the time and angle from the last sample.
  task automatic send_step(input int dt, input int dang);
    send_sample(cur_angle + 16'(dang), cur_stamp + 32'(dt));
  endtask

  // Lower valid, wait for every outstanding rate and let the block settle,
  // so that a register write finds it idle.
  task automatic drain;
    if (burst_left != 0) begin
      samples.valid <= 1'b0;
      burst_left = 0;
    end
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Register write: setup cycle, access cycle, then the bus is released.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [15:0] fc, input logic [2:0] ord);
    drain();
    write_reg(REG_CUTOFF, {16'($urandom_range(0, 65535)), fc});
    write_reg(REG_ORDER, {29'($urandom), ord});
    phases++;
  endtask

  // A phase of random samples. Most steps are plausible intervals with small
  // angle changes so the filter settles; some are full-range jumps, short or
  // backward intervals, and intervals long enough that the coefficient can reach zero.
  task automatic random_phase(input int count);
    int dt, dang;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0:       dt = $urandom_range(0, 6) - 3;
        1:       dt = $urandom;
        2:       dt = $urandom_range(1000000, 40000000);
        default: dt = $urandom_range(2, 100000);
      endcase
      if ($urandom_range(0, 9) == 0) dang = $urandom_range(0, 65535);
      else dang = $urandom_range(0, 400) - 200;
      send_step(dt, dang);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset filter setting. The first sample only
    // stores; then the angle extremes, zero, one and negative intervals.
    cur_stamp = $urandom;
    send_sample(16'sh7FFF, cur_stamp);
    send_step(2, -65535);
    send_step(2, 65535);
    send_step(0, 100);
    send_step(1, -100);
    send_step(-5000, 30);
    send_step(3, 1);
    send_step(32'h7FFF_FFFF, 20);
    send_step(10000, 0);
    send_sample(16'sh8000, 32'hFFFF_FFF0);
    send_sample(16'sh7FFF, 32'h0000_0010);

    // Deepest cascade at the highest cutoff, then an order above the maximum.
    set_filter(16'hFFFF, 3'd4);
    send_step(2, 300);
    send_step(20000, -300);
    send_step(1, 50);
    set_filter(16'd1, 3'd7);
    send_step(5000, 1000);
    send_step(5000, -2000);
    send_step(40000000, 5);
    // Both bypass settings, then the reset values again.
    set_filter(16'd0, 3'd3);
    send_step(1000, 7);
    send_step(1000, -7);
    set_filter(16'd500, 3'd0);
    send_step(1000, 7);
    send_step(1000, 9);
    set_filter(16'd160, 3'd1);

    random_phase(240);
    set_filter(16'hFFFF, 3'd4);
    random_phase(240);
    set_filter(16'd0, 3'd2);
    random_phase(200);
    set_filter(16'd1, 3'd4);
    random_phase(240);
    set_filter(16'd3000, 3'd0);
    random_phase(200);
    set_filter(16'($urandom_range(1, 2000)), 3'd5);
    random_phase(240);
    set_filter(16'($urandom), 3'($urandom_range(1, 3)));
    random_phase(300);

    drain();
    $display("Sent %0d samples over %0d filter settings, cutoff and order",
             sent, phases);
    $display("from bypass to full range, with stalls on both channels.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/srcl_pkg.sv
hdl/srcl_if.sv
hdl/srcl_divider.sv
hdl/steer_rate_cascade_lowpass.sv
verif/srcl_rate_checker.sv
verif/tb_steer_rate_cascade_lowpass.sv
